FILE: hdl/sha1md_pkg.sv
// Shared types and constants of the SHA-1 message digest block.
package sha1md_pkg;

    // Initial chaining values.
    localparam logic [31:0] IV_0 = 32'h67452301;
    localparam logic [31:0] IV_1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_2 = 32'h98BADCFE;
    localparam logic [31:0] IV_3 = 32'h10325476;
    localparam logic [31:0] IV_4 = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    // Round counts and boundaries of the round groups.
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] GROUP_1    = 7'd20;
    localparam logic [6:0] GROUP_2    = 7'd40;
    localparam logic [6:0] GROUP_3    = 7'd60;

    // Padding bytes and positions within a 64-byte block.
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;

    // Five working words a to e; also used for the chaining words.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    // Control of the block buffer and message schedule.
    typedef struct packed {
        logic       push;
        logic [7:0] byte_val;
        logic       advance;
    } t_sched_ctl;

endpackage

FILE: hdl/sha1md_sched.sv
// Block buffer that packs message bytes and then runs the rolling message schedule.
module sha1md_sched
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  t_sched_ctl  i_ctl,
    output logic [31:0] o_word
);

    logic [511:0] r_buf;
    logic [511:0] n_buf;
    logic [31:0]  w_mix;

    // Taps at words 0, 2, 8 and 13 of the sixteen-word window give the next word.
    assign w_mix  = r_buf[511:480] ^ r_buf[447:416] ^ r_buf[255:224] ^ r_buf[95:64];
    assign o_word = r_buf[511:480];

    // Bytes shift in at the bottom, so the first byte ends up most significant.
    always_comb begin
        n_buf = r_buf;
        if (i_ctl.push) begin
            n_buf = {r_buf[503:0], i_ctl.byte_val};
        end else if (i_ctl.advance) begin
            n_buf = {r_buf[479:0], w_mix[30:0], w_mix[31]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

endmodule

FILE: hdl/sha1md_round.sv
// One SHA-1 compression round, shared by all eighty rounds of a block.
module sha1md_round
    import sha1md_pkg::*;
(
    input  t_work       i_work,
    input  logic [31:0] i_word,
    input  logic [6:0]  i_round,
    output t_work       o_work
);

    logic [31:0] w_f;
    logic [31:0] w_k;

    // Select the round function and constant by round group.
    always_comb begin
        if (i_round < GROUP_1) begin
            w_f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            w_k = K_0;
        end else if (i_round < GROUP_2) begin
            w_f = i_work.b ^ i_work.c ^ i_work.d;
            w_k = K_1;
        end else if (i_round < GROUP_3) begin
            w_f = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            w_k = K_2;
        end else begin
            w_f = i_work.b ^ i_work.c ^ i_work.d;
            w_k = K_3;
        end
    end

    // Rotate the words and form the new a.
    always_comb begin
        o_work.a = {i_work.a[26:0], i_work.a[31:27]} + w_f + i_work.e + w_k + i_word;
        o_work.b = i_work.a;
        o_work.c = {i_work.b[1:0], i_work.b[31:2]};
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule

FILE: hdl/sha1_message_digest_top.sv
// SHA-1 message digest: byte intake, padding sequencer, shared round unit and chaining words.
//
// Input channel: one message byte per transaction (i_data_byte with i_has_byte set),
// packed big-endian into 64-byte blocks. A transaction with i_is_last set ends the
// message; it may also carry a final byte, or none for an empty tail.
// Output channel: one 160-bit digest per message, split over o_digest_top,
// o_digest_middle and o_digest_bottom.
// Flow: a byte that does not fill a block is taken without a stall. A byte that fills
// a block is stored, then passes 80 rounds through the single round unit and the
// feed-forward before the next byte is taken. The end of a message feeds the padding
// bytes one per cycle (up to 72 over two blocks), pausing while a full block is
// compressed, and compresses one or two more blocks before the digest is loaded,
// after any wait for an earlier digest still held.
// Reset loads the initial chaining values and empties the block and length counters.
// The digest waits in an output register; further message bytes are taken meanwhile,
// and only the end of the next message stalls until the receiver takes the digest.
// After a digest is issued the block starts over with a fresh message.
module sha1_message_digest_top
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_top,
    output logic [63:0] o_digest_middle,
    output logic [31:0] o_digest_bottom
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FEED  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Padding phases.
    localparam logic [1:0] PH_MARK = 2'd0;
    localparam logic [1:0] PH_ZERO = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;

    localparam t_work IV_WORDS = '{a: IV_0, b: IV_1, c: IV_2, d: IV_3, e: IV_4};

    logic [2:0]  r_state,    n_state;
    logic [6:0]  r_round,    n_round;
    logic [5:0]  r_count,    n_count;
    logic [63:0] r_bitlen,   n_bitlen;
    logic [1:0]  r_phase,    n_phase;
    logic        r_finish,   n_finish;
    logic        r_len_done, n_len_done;
    logic        r_out_valid, n_out_valid;
    t_work       r_chain,    n_chain;
    t_work       r_work,     n_work;
    logic [159:0] r_digest,  n_digest;

    t_sched_ctl  w_ctl;
    logic [31:0] w_word;
    t_work       w_round_out;
    logic        w_in_acc;
    logic        w_is_len;

    sha1md_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_word (w_word)
    );

    sha1md_round u_round (
        .i_work  (r_work),
        .i_word  (w_word),
        .i_round (r_round),
        .o_work  (w_round_out)
    );

    assign o_in_ready      = (r_state == S_IDLE);
    assign w_in_acc        = i_in_valid && o_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_digest_top    = r_digest[159:96];
    assign o_digest_middle = r_digest[95:32];
    assign o_digest_bottom = r_digest[31:0];

    // After the mark, the padding byte at position 56 starts the length field, which runs to the block end.
    assign w_is_len = (r_phase == PH_LEN) || ((r_phase == PH_ZERO) && (r_count == LEN_START));

    // Sequencer: byte intake, padding, rounds, feed-forward and digest hand-off.
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_count     = r_count;
        n_bitlen    = r_bitlen;
        n_phase     = r_phase;
        n_finish    = r_finish;
        n_len_done  = r_len_done;
        n_out_valid = r_out_valid;
        n_chain     = r_chain;
        n_work      = r_work;
        n_digest    = r_digest;
        w_ctl       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_finish = i_is_last;
                    if (i_has_byte) begin
                        w_ctl.push     = 1'b1;
                        w_ctl.byte_val = i_data_byte;
                        n_bitlen       = r_bitlen + 64'd8;
                    end
                    if (i_has_byte && (r_count == BLOCK_LAST)) begin
                        n_state = S_ROUND;
                        n_round = '0;
                        n_work  = r_chain;
                    end else if (i_is_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                w_ctl.push = 1'b1;
                if (r_phase == PH_MARK) begin
                    w_ctl.byte_val = PAD_MARK;
                    n_phase        = PH_ZERO;
                end else if (w_is_len) begin
                    w_ctl.byte_val = r_bitlen[63:56];
                    n_bitlen       = {r_bitlen[55:0], 8'd0};
                    n_phase        = PH_LEN;
                end else begin
                    w_ctl.byte_val = 8'd0;
                end
                if (r_count == BLOCK_LAST) begin
                    n_len_done = w_is_len && (r_phase != PH_MARK);
                    n_state    = S_ROUND;
                    n_round    = '0;
                    n_work     = r_chain;
                end
            end
            S_ROUND: begin
                w_ctl.advance = 1'b1;
                n_work        = w_round_out;
                n_round       = r_round + 7'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_FEED;
                    n_round = '0;
                end
            end
            S_FEED: begin
                n_chain.a = r_chain.a + r_work.a;
                n_chain.b = r_chain.b + r_work.b;
                n_chain.c = r_chain.c + r_work.c;
                n_chain.d = r_chain.d + r_work.d;
                n_chain.e = r_chain.e + r_work.e;
                if (!r_finish) begin
                    n_state = S_IDLE;
                end else if (r_len_done) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_digest    = {r_chain.a, r_chain.b, r_chain.c, r_chain.d, r_chain.e};
                    n_out_valid = 1'b1;
                    n_chain     = IV_WORDS;
                    n_bitlen    = '0;
                    n_phase     = PH_MARK;
                    n_finish    = 1'b0;
                    n_len_done  = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Every pushed byte advances the position in the block.
        if (w_ctl.push) begin
            n_count = r_count + 6'd1;
        end
    end

    // Control state and chaining words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_count     <= '0;
            r_bitlen    <= '0;
            r_phase     <= PH_MARK;
            r_finish    <= 1'b0;
            r_len_done  <= 1'b0;
            r_out_valid <= 1'b0;
            r_chain     <= IV_WORDS;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_count     <= n_count;
            r_bitlen    <= n_bitlen;
            r_phase     <= n_phase;
            r_finish    <= n_finish;
            r_len_done  <= n_len_done;
            r_out_valid <= n_out_valid;
            r_chain     <= n_chain;
        end
    end

    // Working words and digest register.
    always_ff @(posedge i_clk) begin
        r_work   <= n_work;
        r_digest <= n_digest;
    end

endmodule

FILE: bench/sha1_message_digest_top_tb.sv
// Self-checking testbench for the SHA-1 message digest block with a built-in digest predictor.
module sha1_message_digest_top_tb;
    import sha1md_pkg::*;

    // Cycles without any transaction before the run is declared hung.
    localparam int unsigned STALL_LIMIT = 4000;
    // Accepted input transactions to aim for.
    localparam int unsigned ITEM_GOAL   = 1950;
    // From this many items on, neither side idles any more.
    localparam int unsigned CALM_FROM   = 1650;
    // Cycles to keep watching the output once nothing is expected.
    localparam int unsigned DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [63:0] top;
        logic [63:0] middle;
        logic [31:0] bottom;
    } t_digest;

    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       last;
        logic       typed;
        t_digest    want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_has_byte;
    logic        i_is_last;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_digest_top;
    logic [63:0] o_digest_middle;
    logic [31:0] o_digest_bottom;

    // Predictor state: chaining words, block buffer, fill count and bit length.
    logic [31:0] hash_h [5];
    logic [31:0] blk_w [16];
    logic [5:0]  blk_cnt;
    logic [63:0] bit_len;

    t_digest     digest_q [$];
    int unsigned items_sent   = 0;
    int unsigned fails        = 0;
    logic        tail_phase   = 1'b0;
    logic        calm_in      = 1'b0;

    // Directed messages: empty, "abc", extremes of the byte and both ways to end.
    t_stim_row plan [16] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
        '{8'h5a, 1'b0, 1'b0, 1'b0, '0},
        '{8'h61, 1'b1, 1'b0, 1'b0, '0},
        '{8'h62, 1'b1, 1'b0, 1'b0, '0},
        '{8'h63, 1'b1, 1'b1, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
        '{8'hff, 1'b0, 1'b1, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
        '{8'hff, 1'b1, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, 1'b0, '0},
        '{8'h7f, 1'b1, 1'b1, 1'b0, '0},
        '{8'hff, 1'b0, 1'b0, 1'b0, '0},
        '{8'h01, 1'b1, 1'b0, 1'b0, '0},
        '{8'hfe, 1'b1, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, 1'b0, '0},
        '{8'hff, 1'b1, 1'b1, 1'b0, '0}
    };

    sha1_message_digest_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_has_byte      (i_has_byte),
        .i_is_last       (i_is_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_digest_top    (o_digest_top),
        .o_digest_middle (o_digest_middle),
        .o_digest_bottom (o_digest_bottom)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Return the predictor to the start of a fresh message.
    task automatic sha_restart();
        hash_h  = '{IV_0, IV_1, IV_2, IV_3, IV_4};
        blk_cnt = '0;
        bit_len = '0;
    endtask

    // Run the 80 rounds over the full block and fold the result into the chain.
    task automatic sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int          r;
        w = blk_w;
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (r = 0; r < 80; r++) begin
            if (r >= 16) begin
                w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^
                                 w[r % 16], 1);
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end else begin
                f = b ^ c ^ d;
                k = K_3;
            end
            t = rotl(a, 5) + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endtask

    // Shift one byte into the block buffer; a full block is compressed at once.
    task automatic sha_push(input logic [7:0] v);
        blk_w[blk_cnt[5:2]] = {blk_w[blk_cnt[5:2]][23:0], v};
        blk_cnt = blk_cnt + 6'd1;
        if (blk_cnt == '0) begin
            sha_compress();
        end
    endtask

    // Apply one input transaction to the predictor; an end of message yields a digest.
    task automatic sha_absorb(input logic [7:0] d, input logic h, input logic l,
                              output logic done, output t_digest dg);
        logic [63:0] len;
        int          i;
        done = 1'b0;
        dg   = '0;
        if (h) begin
            sha_push(d);
            bit_len = bit_len + 64'd8;
        end
        if (l) begin
            len = bit_len;
            sha_push(PAD_MARK);
            while (blk_cnt != LEN_START) begin
                sha_push(8'h00);
            end
            for (i = 7; i >= 0; i--) begin
                sha_push(len[8 * i +: 8]);
            end
            dg.top    = {hash_h[0], hash_h[1]};
            dg.middle = {hash_h[2], hash_h[3]};
            dg.bottom = hash_h[4];
            done      = 1'b1;
            sha_restart();
        end
    endtask

    // Offer one transaction, wait for its acceptance, predict, then maybe idle a while.
    task automatic send_item(input logic [7:0] d, input logic h, input logic l,
                             input logic typed, input t_digest want);
        logic    got;
        t_digest dg;
        i_in_valid  <= 1'b1;
        i_data_byte <= d;
        i_has_byte  <= h;
        i_is_last   <= l;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sha_absorb(d, h, l, got, dg);
        if (got) begin
            digest_q = {digest_q, (typed ? want : dg)};
        end
        items_sent++;
        tail_phase = (items_sent >= CALM_FROM);
        if (!tail_phase && !calm_in && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // One random message of the given length, with occasional ignored items mixed in.
    task automatic send_message(input int unsigned len);
        int unsigned n;
        logic        end_with_byte;
        end_with_byte = (len > 0) && $urandom_range(0, 1);
        for (n = 0; n < len; n++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
            end
            send_item(8'($urandom_range(0, 255)), 1'b1, end_with_byte && (n == len - 1),
                      1'b0, '0);
        end
        if (!end_with_byte) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
        end
    endtask

    // Message lengths cluster around the padding boundaries, mostly short.
    function automatic int unsigned pick_length();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 8);
            3:       return $urandom_range(52, 60);
            4:       return $urandom_range(60, 68);
            5:       return $urandom_range(116, 124);
            6, 7:    return $urandom_range(1, 40);
            8:       return $urandom_range(180, 260);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    // Output side: ready with random stall bursts, none near the end of the run.
    initial begin : out_ready_drive
        int unsigned stall;
        int unsigned cyc;
        logic        calm_out;
        stall       = 0;
        cyc         = 0;
        calm_out    = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 256 == 0) begin
                calm_out = ($urandom_range(0, 3) == 0);
            end
            if (stall == 0 && !tail_phase && !calm_out && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 14);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare each digest transaction against the oldest expected digest.
    always @(posedge i_clk) begin : digest_check
        t_digest want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_q.size() == 0) begin
                fails++;
                if (fails <= 10) begin
                    $display("unexpected digest %h %h %h", o_digest_top, o_digest_middle,
                             o_digest_bottom);
                end
            end else begin
                want = digest_q.pop_front();
                if (want.top !== o_digest_top || want.middle !== o_digest_middle ||
                    want.bottom !== o_digest_bottom) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("digest mismatch: expected %h %h %h, got %h %h %h",
                                 want.top, want.middle, want.bottom,
                                 o_digest_top, o_digest_middle, o_digest_bottom);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side ends the run.
    always @(posedge i_clk) begin : hang_watch
        int unsigned quiet_cycles;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Reset, directed table, random messages, then drain and report.
    initial begin : stimulus
        int unsigned row;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= '0;
        i_has_byte  <= 1'b0;
        i_is_last   <= 1'b0;
        blk_w       = '{default: '0};
        sha_restart();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < $size(plan); row++) begin
            send_item(plan[row].data, plan[row].has, plan[row].last, plan[row].typed,
                      plan[row].want);
        end

        while (items_sent < ITEM_GOAL) begin
            calm_in = ($urandom_range(0, 3) == 0);
            send_message(pick_length());
        end
        i_in_valid <= 1'b0;

        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sha1_message_digest_top.f
hdl/sha1md_pkg.sv
hdl/sha1md_sched.sv
hdl/sha1md_round.sv
hdl/sha1_message_digest_top.sv
bench/sha1_message_digest_top_tb.sv
